// ===== hdl/pal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes of the positional array list: request and response
// words, mode and status codes, and the command that goes to the cell row.
// ----------------------------------------------------------------------------
package pal_pkg;

    // request modes
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // response status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // request word
    typedef struct packed {
        mode_t                     mode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    // response word
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } rsp_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/pal_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Holds a single entry; on insert it loads the new value or its
// left neighbor, on delete it loads its right neighbor, otherwise it holds.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire                                   clk,
    input  wire pal_pkg::cell_cmd_t               cmd,
    input  wire [IW-1:0]                          pidx,
    input  wire logic signed [pal_pkg::DATA_W-1:0] ins_value,
    input  wire logic signed [pal_pkg::DATA_W-1:0] left_entry,
    input  wire logic signed [pal_pkg::DATA_W-1:0] right_entry,
    output logic signed [pal_pkg::DATA_W-1:0]     entry,
    output logic signed [pal_pkg::DATA_W-1:0]     read_data
);

    logic signed [pal_pkg::DATA_W-1:0] entry_reg;
    logic signed [pal_pkg::DATA_W-1:0] entry_next;
    logic                              hit;
    logic                              above;

    // where this slot sits relative to the target position
    assign hit   = (pidx == IW'(IDX));
    assign above = (pidx < IW'(IDX));

    // slot update
    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.ins && hit)
            entry_next = ins_value;
        else if (cmd.ins && above)
            entry_next = left_entry;
        else if (cmd.del && (hit || above))
            entry_next = right_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    // contributes to the read bus only when addressed
    assign read_data = hit ? entry_reg : '0;

endmodule
`default_nettype wire

// ===== hdl/positional_array_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list addressed by 1-based position, with insert,
// delete, read and clear. Entries live in a row of cells that shift together.
// ----------------------------------------------------------------------------
//   channel | signals                    | word
//   --------+----------------------------+--------------------------------
//   request | req_valid, req_stall, req  | mode, position, value
//   result  | rsp_valid, rsp_stall, rsp  | status, data_out, count, is_empty
//
// The whole cell row shifts in parallel, so a new request can be accepted
// every cycle while req_stall is low, and its result shows the next cycle.
// Reset clears the entry count and the result valid flag; cell contents are left as they are.
// The request side stalls while a result is held and the result side stalls.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int CAPACITY = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire pal_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output pal_pkg::rsp_t       rsp
);

    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((FW > pal_pkg::POS_W) ? FW : pal_pkg::POS_W) + 1;

    logic [FW-1:0]                      fill_reg;
    logic [FW-1:0]                      fill_next;
    logic                               rsp_valid_reg;
    pal_pkg::rsp_t                      rsp_reg;
    pal_pkg::rsp_t                      rsp_next;
    pal_pkg::cell_cmd_t                 cmd;
    logic                               accept;
    logic [CMPW-1:0]                    fill_ext;
    logic [CMPW-1:0]                    pos_ext;
    logic [IW-1:0]                      pidx;
    logic                               pos_ok_ins;
    logic                               pos_ok_rd;
    logic                               full;
    logic signed [pal_pkg::DATA_W-1:0]  entry_w [CAPACITY];
    logic signed [pal_pkg::DATA_W-1:0]  rdata_w [CAPACITY];
    logic signed [pal_pkg::DATA_W-1:0]  rd_bus;

    assign accept    = req_valid && !req_stall;
    assign req_stall = rsp_valid_reg && rsp_stall;

    // position checks against the current fill
    assign fill_ext   = CMPW'(fill_reg);
    assign pos_ext    = CMPW'(req.position);
    assign pidx       = IW'(pos_ext - CMPW'(1));
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= fill_ext + CMPW'(1));
    assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= fill_ext);
    assign full       = (fill_ext >= CMPW'(CAPACITY));

    // request decode and result word
    always_comb
    begin
        fill_next         = fill_reg;
        cmd               = '0;
        rsp_next.status   = pal_pkg::ST_OK;
        rsp_next.data_out = '0;
        unique case (req.mode)
            pal_pkg::MODE_INSERT:
            begin
                if (!pos_ok_ins)
                    rsp_next.status = pal_pkg::ST_RANGE;
                else if (full)
                    rsp_next.status = pal_pkg::ST_FULL;
                else
                begin
                    cmd.ins   = accept;
                    fill_next = fill_reg + FW'(1);
                end
            end
            pal_pkg::MODE_DELETE:
            begin
                if (!pos_ok_rd)
                    rsp_next.status = pal_pkg::ST_RANGE;
                else
                begin
                    cmd.del           = accept;
                    rsp_next.data_out = rd_bus;
                    fill_next         = fill_reg - FW'(1);
                end
            end
            pal_pkg::MODE_READ:
            begin
                if (!pos_ok_rd)
                    rsp_next.status = pal_pkg::ST_RANGE;
                else
                    rsp_next.data_out = rd_bus;
            end
            pal_pkg::MODE_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        rsp_next.count    = pal_pkg::COUNT_W'(fill_next);
        rsp_next.is_empty = (fill_next == '0);
    end

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] left_w;
        logic signed [pal_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        pal_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pidx        (pidx),
            .ins_value   (req.value),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .read_data   (rdata_w[i])
        );
    end

    // read bus: only the addressed cell drives nonzero
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_bus = rd_bus | rdata_w[k];
    end

    // fill count and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_ext <= CMPW'(CAPACITY))
        else $error("fill exceeds capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.ins |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not grow the list");

    a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.del |=> fill_reg == $past(fill_reg) - FW'(1))
        else $error("delete did not shrink the list");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == pal_pkg::ST_RANGE |-> rsp_reg.data_out == '0)
        else $error("rejected request carries data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rsp_next.status == pal_pkg::ST_FULL |=>
            rsp_reg.count == pal_pkg::COUNT_W'(CAPACITY))
        else $error("full status with list not full");

endmodule
`default_nettype wire
